[hdl/sss_pkg.sv]
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and constants of the servo sweep sequencer.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_REST_PULSE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_SIZE   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RAMP_STEPS  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HOLD_TICKS  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BLINK_TICKS = 3'd4;

    // register values after reset
    localparam logic [15:0] REST_PULSE_RST  = 16'd500;
    localparam logic [9:0]  STEP_SIZE_RST   = 10'd20;
    localparam logic [7:0]  RAMP_STEPS_RST  = 8'd50;
    localparam logic [15:0] HOLD_TICKS_RST  = 16'd500;
    localparam logic [7:0]  BLINK_TICKS_RST = 8'd5;

    typedef enum logic [1:0] {
        PH_UP   = 2'd0,
        PH_HOLD = 2'd1,
        PH_DOWN = 2'd2
    } phase_t;

    typedef struct packed {
        logic [9:0]  step_size;
        logic [7:0]  ramp_steps;
        logic [15:0] hold_ticks;
        logic [7:0]  blink_ticks;
    } cfg_t;

    typedef struct packed {
        logic        running;
        phase_t      phase;
        logic [7:0]  step_count;
        logic [15:0] hold_count;
        logic [7:0]  blink_count;
        logic        blink_flag;
        logic        led_level;
        logic [15:0] pulse;
    } sweep_state_t;

endpackage

[hdl/servo_sweep_sequencer.sv]
// ----------------------------------------------------------------------------
// servo_sweep_sequencer
// Servo sweep sequencer: ramp up, hold, ramp down, with a blinking LED.
//
//   channel   dir  handshake           tdata / data bits (lowest first)
//   s_axis    in   s_tvalid/s_tready   start_request[0], zero [7:1]
//   m_axis    out  m_tvalid/m_tready   pulse_width[15:0], led_on[16],
//                                      busy_res[17], sweep_phase[19:18]
//   cfg       in   cfg_we              cfg_addr index, cfg_wdata value
//
// one word per cycle while the output is not stalled; a tick goes input register
// -> state register, and the state register update gives its result
// the sweep state register doubles as the result register
// reset clears both stages and loads the register defaults, pulse 500
// a stalled output holds the state; the input stage takes one more word
// ----------------------------------------------------------------------------
module servo_sweep_sequencer
    import sss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // start_request
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // pulse_width, led_on, busy_res, sweep_phase
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t         cfg;
    sweep_state_t state_reg;
    sweep_state_t state_next;
    logic         in_vld_reg;
    logic         in_start_reg;
    logic         out_vld_reg;
    logic         advance;

    sss_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sss_step u_step (
        .start (in_start_reg),
        .cfg   (cfg),
        .cur   (state_reg),
        .nxt   (state_next)
    );

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            in_start_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg   <= s_tvalid;
            in_start_reg <= s_tdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg           <= 1'b0;
            state_reg.running     <= 1'b0;
            state_reg.phase       <= PH_UP;
            state_reg.step_count  <= 8'd0;
            state_reg.hold_count  <= 16'd0;
            state_reg.blink_count <= 8'd0;
            state_reg.blink_flag  <= 1'b0;
            state_reg.led_level   <= 1'b0;
            state_reg.pulse       <= REST_PULSE_RST;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'd0, state_reg.phase, state_reg.running,
                       state_reg.led_level, state_reg.pulse};

endmodule

[hdl/sss_cfg.sv]
// ----------------------------------------------------------------------------
// sss_cfg
// Configuration registers, written by index on a plain write port.
// ----------------------------------------------------------------------------
module sss_cfg
    import sss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // rest pulse only matters as the pulse reset value, which is fixed at reset,
    // so a write to it changes nothing that can be seen
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size   <= STEP_SIZE_RST;
            cfg_reg.ramp_steps  <= RAMP_STEPS_RST;
            cfg_reg.hold_ticks  <= HOLD_TICKS_RST;
            cfg_reg.blink_ticks <= BLINK_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_REST_PULSE:  ;
                REG_STEP_SIZE:   cfg_reg.step_size   <= cfg_wdata[9:0];
                REG_RAMP_STEPS:  cfg_reg.ramp_steps  <= cfg_wdata[7:0];
                REG_HOLD_TICKS:  cfg_reg.hold_ticks  <= cfg_wdata;
                REG_BLINK_TICKS: cfg_reg.blink_ticks <= cfg_wdata[7:0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/sss_step.sv]
// ----------------------------------------------------------------------------
// sss_step
// Next sweep state for one timer tick.
// ----------------------------------------------------------------------------
module sss_step
    import sss_pkg::*;
(
    input  logic         start,
    input  cfg_t         cfg,
    input  sweep_state_t cur,
    output sweep_state_t nxt
);

    logic        active;
    logic [16:0] up_sum;
    logic [15:0] up_sat;
    logic [15:0] down_sat;
    logic [15:0] hold_inc;
    logic [7:0]  blink_inc;

    assign active    = cur.running | start;
    assign up_sum    = {1'b0, cur.pulse} + {7'd0, cfg.step_size};
    assign up_sat    = up_sum[16] ? 16'hFFFF : up_sum[15:0];
    assign down_sat  = (cur.pulse > {6'd0, cfg.step_size})
                       ? cur.pulse - {6'd0, cfg.step_size} : 16'd0;
    assign hold_inc  = (cur.hold_count != 16'hFFFF) ? cur.hold_count + 16'd1
                                                    : cur.hold_count;
    assign blink_inc = (cur.blink_count != 8'hFF) ? cur.blink_count + 8'd1
                                                  : cur.blink_count;

    always_comb
    begin
        nxt = cur;
        nxt.running = active;
        if (active)
        begin
            case (cur.phase)
                PH_UP:
                begin
                    if (cur.step_count < cfg.ramp_steps)
                    begin
                        nxt.pulse      = up_sat;
                        nxt.step_count = cur.step_count + 8'd1;
                    end
                    else
                    begin
                        nxt.phase      = PH_HOLD;
                        nxt.step_count = 8'd0;
                    end
                end
                PH_HOLD:
                begin
                    if (hold_inc >= cfg.hold_ticks)
                    begin
                        nxt.phase      = PH_DOWN;
                        nxt.hold_count = 16'd0;
                    end
                    else
                    begin
                        nxt.hold_count = hold_inc;
                    end
                end
                PH_DOWN:
                begin
                    if (cur.step_count < cfg.ramp_steps)
                    begin
                        nxt.pulse      = down_sat;
                        nxt.step_count = cur.step_count + 8'd1;
                    end
                    else
                    begin
                        // stop: led cleared here, blink rule below may set it again
                        nxt.phase      = PH_UP;
                        nxt.running    = 1'b0;
                        nxt.step_count = 8'd0;
                        nxt.led_level  = 1'b0;
                    end
                end
                default: ;
            endcase

            nxt.blink_count = blink_inc;
            if (nxt.phase == PH_UP || nxt.phase == PH_DOWN)
            begin
                if (blink_inc >= cfg.blink_ticks)
                begin
                    nxt.blink_flag  = ~cur.blink_flag;
                    nxt.led_level   = ~cur.blink_flag;
                    nxt.blink_count = 8'd0;
                end
            end
            else if (nxt.phase == PH_HOLD)
            begin
                nxt.led_level = 1'b0;
            end
        end
    end

endmodule

[hdl/sss_checker.sv]
// ----------------------------------------------------------------------------
// sss_checker
// Port-level checks on the servo sweep sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module sss_checker
    import sss_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // idle always reports the ramp up phase
    a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[17] |-> m_tdata[19:18] == PH_UP)
        else $error("idle with nonzero phase");

    // led forced off during hold
    a_hold_led: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[19:18] == PH_HOLD |-> !m_tdata[16])
        else $error("led on during hold");

    // phase code three never appears
    a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[19:18] != 2'b11)
        else $error("illegal phase code");

endmodule

bind servo_sweep_sequencer sss_checker u_sss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
